// File: rtl/core/tcfd_pkg.sv
`default_nettype none

package tcfd_pkg;

    // Grid limits
    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 128;

    localparam int COL_W      = $clog2(MAX_COLUMNS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int ADDR_W     = COL_W + ROW_W;
    localparam int CELL_DEPTH = 2 ** ADDR_W;

    // Size registers hold 1..MAX inclusive
    localparam int COLS_W = $clog2(MAX_COLUMNS + 1);
    localparam int ROWS_W = $clog2(MAX_ROWS + 1);
    localparam int CFG_W  = (COLS_W > ROWS_W) ? COLS_W : ROWS_W;
    localparam int CFG_INDEX_W = 2;

    localparam int COLUMNS_RESET = 80;
    localparam int ROWS_RESET    = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS    = 2'd1;

    // Cell fields
    localparam int SYM_W   = 21;
    localparam int COLOR_W = 8;
    localparam int TRAIT_W = 8;

    // Operation codes; code 3 only visits and advances
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_MERGE = 2'd0;
    localparam logic [OP_W-1:0] OP_COLOR = 2'd1;
    localparam logic [OP_W-1:0] OP_FULL  = 2'd2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [TRAIT_W-1:0] traits;
        logic [COLOR_W-1:0] background;
        logic [COLOR_W-1:0] foreground;
        logic [SYM_W-1:0]   symbol;
    } cell_t;

    localparam int CELL_W = $bits(cell_t);

    typedef struct packed {
        logic [OP_W-1:0]    op;
        cell_t              content;
        logic [COLOR_W-1:0] color;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic               last;
    } item_t;

    typedef struct packed {
        logic             strobe;
        logic             report;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        cell_t            content;
        logic             last;
    } result_t;

    typedef struct packed {
        logic clearing;
        logic queue_full;
    } hold_t;

endpackage

`default_nettype wire

// File: rtl/core/tcfd_ram.sv
`default_nettype none

module tcfd_ram #(
    parameter int WIDTH = 45,
    parameter int DEPTH = 32768
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first: a read of the address being written returns old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/tcfd_queue.sv
`default_nettype none

module tcfd_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire tcfd_pkg::item_t din,
    input  wire logic            pop,
    output tcfd_pkg::item_t      dout,
    output logic                 empty,
    output logic                 full
);

    tcfd_pkg::item_t entry_reg [tcfd_pkg::QUEUE_DEPTH];

    logic [tcfd_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tcfd_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tcfd_pkg::QCNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == tcfd_pkg::QCNT_W'(tcfd_pkg::QUEUE_DEPTH));
    assign dout  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == tcfd_pkg::QPTR_W'(tcfd_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == tcfd_pkg::QPTR_W'(tcfd_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tcfd_front.sv
`default_nettype none

module tcfd_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire tcfd_pkg::hold_t                     hold,
    output logic                                     busy,
    input  wire logic [tcfd_pkg::OP_W-1:0]           operation,
    input  wire logic [tcfd_pkg::SYM_W-1:0]          in_symbol,
    input  wire logic [tcfd_pkg::COLOR_W-1:0]        in_foreground,
    input  wire logic [tcfd_pkg::COLOR_W-1:0]        in_background,
    input  wire logic [tcfd_pkg::TRAIT_W-1:0]        in_traits,
    input  wire logic [tcfd_pkg::COLOR_W-1:0]        match_color,
    input  wire logic                                cfg_write,
    input  wire logic [tcfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [tcfd_pkg::CFG_W-1:0]          cfg_data,
    output logic                                     push,
    output tcfd_pkg::item_t                          item
);

    logic [tcfd_pkg::COLS_W-1:0] cols_reg, cols_next;
    logic [tcfd_pkg::ROWS_W-1:0] rows_reg, rows_next;
    logic [tcfd_pkg::COL_W-1:0]  col_reg, col_next;
    logic [tcfd_pkg::ROW_W-1:0]  row_reg, row_next;

    logic [tcfd_pkg::COLS_W-1:0] col_plus;
    logic [tcfd_pkg::ROWS_W-1:0] row_plus;
    logic                        col_wrap;
    logic                        row_wrap;
    logic [tcfd_pkg::COLS_W-1:0] cols_raw;
    logic [tcfd_pkg::ROWS_W-1:0] rows_raw;

    assign busy = hold.clearing || hold.queue_full;
    assign push = start && !busy;

    assign col_plus = tcfd_pkg::COLS_W'(col_reg) + 1'b1;
    assign row_plus = tcfd_pkg::ROWS_W'(row_reg) + 1'b1;
    assign col_wrap = (col_plus >= cols_reg);
    assign row_wrap = (row_plus >= rows_reg);

    assign cols_raw = cfg_data[tcfd_pkg::COLS_W-1:0];
    assign rows_raw = cfg_data[tcfd_pkg::ROWS_W-1:0];

    always_comb
    begin
        item.op                 = operation;
        item.content.symbol     = in_symbol;
        item.content.foreground = in_foreground;
        item.content.background = in_background;
        item.content.traits     = in_traits;
        item.color              = match_color;
        item.col                = col_reg;
        item.row                = row_reg;
        item.last               = col_wrap && row_wrap;
    end

    always_comb
    begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (cfg_write && cfg_index == tcfd_pkg::CFG_COLUMNS)
        begin
            if (cols_raw == '0)
            begin
                cols_next = tcfd_pkg::COLS_W'(1);
            end
            else if (cols_raw > tcfd_pkg::COLS_W'(tcfd_pkg::MAX_COLUMNS))
            begin
                cols_next = tcfd_pkg::COLS_W'(tcfd_pkg::MAX_COLUMNS);
            end
            else
            begin
                cols_next = cols_raw;
            end
            col_next = '0;
            row_next = '0;
        end
        else if (cfg_write && cfg_index == tcfd_pkg::CFG_ROWS)
        begin
            if (rows_raw == '0)
            begin
                rows_next = tcfd_pkg::ROWS_W'(1);
            end
            else if (rows_raw > tcfd_pkg::ROWS_W'(tcfd_pkg::MAX_ROWS))
            begin
                rows_next = tcfd_pkg::ROWS_W'(tcfd_pkg::MAX_ROWS);
            end
            else
            begin
                rows_next = rows_raw;
            end
            col_next = '0;
            row_next = '0;
        end
        else if (push)
        begin
            if (!col_wrap)
            begin
                col_next = col_plus[tcfd_pkg::COL_W-1:0];
            end
            else
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_plus[tcfd_pkg::ROW_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= tcfd_pkg::COLS_W'(tcfd_pkg::COLUMNS_RESET);
            rows_reg <= tcfd_pkg::ROWS_W'(tcfd_pkg::ROWS_RESET);
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else
        begin
            cols_reg <= cols_next;
            rows_reg <= rows_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tcfd_back.sv
`default_nettype none

module tcfd_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire tcfd_pkg::item_t head,
    input  wire logic            queue_empty,
    output logic                 pop,
    output logic                 clearing,
    output tcfd_pkg::result_t    result
);

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } state_t;

    state_t                      state_reg, state_next;
    logic [tcfd_pkg::ADDR_W-1:0] clear_addr_reg, clear_addr_next;

    // execute stage: RAM data for this item arrives this cycle
    logic                        e_valid_reg, e_valid_next;
    tcfd_pkg::item_t             e_item_reg, e_item_next;

    // last write, for a read issued in the same cycle as that write
    logic                        fw_valid_reg, fw_valid_next;
    logic [tcfd_pkg::ADDR_W-1:0] fw_addr_reg, fw_addr_next;
    tcfd_pkg::cell_t             fw_cell_reg, fw_cell_next;

    tcfd_pkg::result_t           result_reg, result_next;

    logic                        ram_we;
    logic [tcfd_pkg::ADDR_W-1:0] ram_waddr;
    tcfd_pkg::cell_t             ram_wdata;
    logic [tcfd_pkg::ADDR_W-1:0] ram_raddr;
    logic [tcfd_pkg::CELL_W-1:0] ram_rdata;

    logic [tcfd_pkg::ADDR_W-1:0] e_addr;
    tcfd_pkg::cell_t             stored;
    tcfd_pkg::cell_t             cell_out;
    logic                        e_write;
    logic                        e_report;

    assign clearing  = (state_reg == ST_CLEAR);
    assign pop       = !clearing && !queue_empty;
    assign ram_raddr = {head.row, head.col};
    assign e_addr    = {e_item_reg.row, e_item_reg.col};
    assign result    = result_reg;

    tcfd_ram #(
        .WIDTH (tcfd_pkg::CELL_W),
        .DEPTH (tcfd_pkg::CELL_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        stored = (fw_valid_reg && fw_addr_reg == e_addr) ? fw_cell_reg :
                 tcfd_pkg::cell_t'(ram_rdata);
        e_write  = 1'b0;
        e_report = 1'b0;
        case (e_item_reg.op)
            tcfd_pkg::OP_MERGE:
            begin
                e_write  = (e_item_reg.content.symbol != '0) &&
                           (e_item_reg.content != stored);
                e_report = e_write;
            end
            tcfd_pkg::OP_COLOR:
            begin
                e_report = (stored.foreground == e_item_reg.color) ||
                           (stored.background == e_item_reg.color);
            end
            tcfd_pkg::OP_FULL:
            begin
                e_report = 1'b1;
            end
            default:
            begin
                e_report = 1'b0;
            end
        endcase
        e_write  = e_write && e_valid_reg;
        cell_out = e_write ? e_item_reg.content : stored;
    end

    always_comb
    begin
        if (clearing)
        begin
            ram_we    = 1'b1;
            ram_waddr = clear_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = e_write;
            ram_waddr = e_addr;
            ram_wdata = e_item_reg.content;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clear_addr_next = clear_addr_reg;
        e_valid_next    = pop;
        e_item_next     = head;
        fw_valid_next   = e_write;
        fw_addr_next    = e_addr;
        fw_cell_next    = e_item_reg.content;

        result_next.strobe  = e_valid_reg;
        result_next.report  = e_report;
        result_next.col     = e_item_reg.col;
        result_next.row     = e_item_reg.row;
        result_next.content = cell_out;
        result_next.last    = e_item_reg.last;

        case (state_reg)
            ST_CLEAR:
            begin
                clear_addr_next = clear_addr_reg + 1'b1;
                if (clear_addr_reg == tcfd_pkg::ADDR_W'(tcfd_pkg::CELL_DEPTH - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clear_addr_reg <= '0;
            e_valid_reg    <= 1'b0;
            e_item_reg     <= '0;
            fw_valid_reg   <= 1'b0;
            fw_addr_reg    <= '0;
            fw_cell_reg    <= '0;
            result_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
            e_valid_reg    <= e_valid_next;
            e_item_reg     <= e_item_next;
            fw_valid_reg   <= fw_valid_next;
            fw_addr_reg    <= fw_addr_next;
            fw_cell_reg    <= fw_cell_next;
            result_reg     <= result_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/text_cell_frame_diff_unit.sv
`default_nettype none
// Character-cell frame store with change reporting.
// Input: an item is taken at a clock edge with start high and busy low; operation picks
// merge, color scan, full scan or bare visit of the cell at (column, row), the current
// position, which then steps on in row-major order and wraps after the last grid cell.
// Output: every item gives one beat, on the result ports with result_strobe high for
// one cycle; it passes the queue, the execute stage and the result register in order.
// The receiver has no way to stall; beats come out in order and must be taken as they
// appear.
// Throughput: one item per cycle while busy is low. Each item is one read and at most
// one write of the cell RAM (one read port, one write port); a write is forwarded to the
// next read, so back-to-back visits of the same cell (a one-cell grid) need no bubble.
// A two-entry queue sits between the front (position, grid size) and the back (RAM,
// compare); busy goes high only when the queue is full or during the clear pass.
// Reset: grid returns to 80 x 24, position to (0, 0), and a clear pass writes every
// one of the 32768 cells to blank, one per cycle; busy stays high during the pass.
// Configuration writes (cfg_write, cfg_index, cfg_data) are taken at once, even
// during the clear pass; a size write also homes the position.
module text_cell_frame_diff_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [tcfd_pkg::OP_W-1:0]           operation,
    input  wire logic [tcfd_pkg::SYM_W-1:0]          in_symbol,
    input  wire logic [tcfd_pkg::COLOR_W-1:0]        in_foreground,
    input  wire logic [tcfd_pkg::COLOR_W-1:0]        in_background,
    input  wire logic [tcfd_pkg::TRAIT_W-1:0]        in_traits,
    input  wire logic [tcfd_pkg::COLOR_W-1:0]        match_color,
    input  wire logic                                cfg_write,
    input  wire logic [tcfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [tcfd_pkg::CFG_W-1:0]          cfg_data,
    output logic                                     result_strobe,
    output logic                                     report,
    output logic [tcfd_pkg::COL_W-1:0]               cell_column,
    output logic [tcfd_pkg::ROW_W-1:0]               cell_row,
    output logic [tcfd_pkg::SYM_W-1:0]               out_symbol,
    output logic [tcfd_pkg::COLOR_W-1:0]             out_foreground,
    output logic [tcfd_pkg::COLOR_W-1:0]             out_background,
    output logic [tcfd_pkg::TRAIT_W-1:0]             out_traits,
    output logic                                     last_cell
);

    tcfd_pkg::hold_t   hold;
    tcfd_pkg::item_t   push_item;
    tcfd_pkg::item_t   head_item;
    tcfd_pkg::result_t result;
    logic              push;
    logic              pop;
    logic              queue_empty;
    logic              queue_full;
    logic              clearing;

    assign hold.clearing   = clearing;
    assign hold.queue_full = queue_full;

    tcfd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .hold          (hold),
        .busy          (busy),
        .operation     (operation),
        .in_symbol     (in_symbol),
        .in_foreground (in_foreground),
        .in_background (in_background),
        .in_traits     (in_traits),
        .match_color   (match_color),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .item          (push_item)
    );

    tcfd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_item),
        .pop   (pop),
        .dout  (head_item),
        .empty (queue_empty),
        .full  (queue_full)
    );

    tcfd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_item),
        .queue_empty (queue_empty),
        .pop         (pop),
        .clearing    (clearing),
        .result      (result)
    );

    assign result_strobe  = result.strobe;
    assign report         = result.report;
    assign cell_column    = result.col;
    assign cell_row       = result.row;
    assign out_symbol     = result.content.symbol;
    assign out_foreground = result.content.foreground;
    assign out_background = result.content.background;
    assign out_traits     = result.content.traits;
    assign last_cell      = result.last;

endmodule

`default_nettype wire

// File: rtl/core/tcfd_checker.sv
`default_nettype none

module tcfd_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic [tcfd_pkg::OP_W-1:0]     operation,
    input wire logic [tcfd_pkg::SYM_W-1:0]    in_symbol,
    input wire logic                          result_strobe,
    input wire logic                          report
);

    logic accept;

    assign accept = start && !busy;

    // every beat in gives exactly one beat out
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 result_strobe)
        else $error("accepted item produced no result");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(accept, 3))
        else $error("result without a matching item");

    a_full_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == tcfd_pkg::OP_FULL) |-> ##3 report)
        else $error("full scan step not reported");

    a_blank_merge: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == tcfd_pkg::OP_MERGE && in_symbol == '0) |-> ##3 !report)
        else $error("merge of blank symbol reported a change");

endmodule

bind text_cell_frame_diff_unit tcfd_checker u_tcfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .in_symbol     (in_symbol),
    .result_strobe (result_strobe),
    .report        (report)
);

`default_nettype wire

// File: sim/tb_top.sv
`default_nettype none

module tb_top;

    localparam int OP_W          = tcfd_pkg::OP_W;
    localparam int CFG_INDEX_W   = tcfd_pkg::CFG_INDEX_W;
    localparam int CFG_W         = tcfd_pkg::CFG_W;
    localparam int COLS_W        = tcfd_pkg::COLS_W;
    localparam int ROWS_W        = tcfd_pkg::ROWS_W;
    localparam int COL_W         = tcfd_pkg::COL_W;
    localparam int ROW_W         = tcfd_pkg::ROW_W;
    localparam int SYM_W         = tcfd_pkg::SYM_W;
    localparam int COLOR_W       = tcfd_pkg::COLOR_W;
    localparam int TRAIT_W       = tcfd_pkg::TRAIT_W;
    localparam int CELL_DEPTH    = tcfd_pkg::CELL_DEPTH;
    localparam int MAX_COLUMNS   = tcfd_pkg::MAX_COLUMNS;
    localparam int MAX_ROWS      = tcfd_pkg::MAX_ROWS;
    localparam int COLUMNS_RESET = tcfd_pkg::COLUMNS_RESET;
    localparam int ROWS_RESET    = tcfd_pkg::ROWS_RESET;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS = tcfd_pkg::CFG_COLUMNS;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS    = tcfd_pkg::CFG_ROWS;
    localparam logic [OP_W-1:0] OP_MERGE = tcfd_pkg::OP_MERGE;
    localparam logic [OP_W-1:0] OP_COLOR = tcfd_pkg::OP_COLOR;
    localparam logic [OP_W-1:0] OP_FULL  = tcfd_pkg::OP_FULL;

    typedef tcfd_pkg::cell_t cell_t;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int SYM_MAX      = 'h10FFFF;
    localparam int RANDOM_ITEMS = 560;
    localparam int DRAIN_PAD    = 8;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int PLAN_ROWS    = 33;
    localparam cell_t BLANK     = '0;

    typedef struct packed {
        logic             report;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        cell_t            content;
        logic             last;
    } beat_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [OP_W-1:0]        op;
        cell_t                  in_cell;
        logic [COLOR_W-1:0]     color;
        logic                   typed;
        logic                   t_report;
        cell_t                  t_cell;
        logic [CFG_INDEX_W-1:0] cfg_idx;
        logic [CFG_W-1:0]       cfg_val;
    } stim_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [OP_W-1:0]        operation     = '0;
    logic [SYM_W-1:0]       in_symbol     = '0;
    logic [COLOR_W-1:0]     in_foreground = '0;
    logic [COLOR_W-1:0]     in_background = '0;
    logic [TRAIT_W-1:0]     in_traits     = '0;
    logic [COLOR_W-1:0]     match_color   = '0;
    logic                   cfg_write     = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]       cfg_data      = '0;

    logic               busy;
    logic               result_strobe;
    logic               report;
    logic [COL_W-1:0]   cell_column;
    logic [ROW_W-1:0]   cell_row;
    logic [SYM_W-1:0]   out_symbol;
    logic [COLOR_W-1:0] out_foreground;
    logic [COLOR_W-1:0] out_background;
    logic [TRAIT_W-1:0] out_traits;
    logic               last_cell;

    // shadow frame store and position
    cell_t       frame_mem [CELL_DEPTH];
    int unsigned pos_col   = 0;
    int unsigned pos_row   = 0;
    int unsigned grid_cols = COLUMNS_RESET;
    int unsigned grid_rows = ROWS_RESET;

    beat_t       pending_beats [$];
    stim_row_t   plan [PLAN_ROWS];
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;

    text_cell_frame_diff_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .in_symbol      (in_symbol),
        .in_foreground  (in_foreground),
        .in_background  (in_background),
        .in_traits      (in_traits),
        .match_color    (match_color),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_strobe  (result_strobe),
        .report         (report),
        .cell_column    (cell_column),
        .cell_row       (cell_row),
        .out_symbol     (out_symbol),
        .out_foreground (out_foreground),
        .out_background (out_background),
        .out_traits     (out_traits),
        .last_cell      (last_cell)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic cell_t mk_cell(input logic [SYM_W-1:0] sym, input logic [COLOR_W-1:0] fg,
                                      input logic [COLOR_W-1:0] bg, input logic [TRAIT_W-1:0] tr);
        cell_t c;
        c.symbol     = sym;
        c.foreground = fg;
        c.background = bg;
        c.traits     = tr;
        return c;
    endfunction

    function automatic stim_row_t typed_row(input logic [OP_W-1:0] op, input cell_t c,
                                            input logic [COLOR_W-1:0] color, input logic rep,
                                            input cell_t e);
        stim_row_t r;
        r          = '0;
        r.kind     = ROW_ITEM;
        r.op       = op;
        r.in_cell  = c;
        r.color    = color;
        r.typed    = 1'b1;
        r.t_report = rep;
        r.t_cell   = e;
        return r;
    endfunction

    function automatic stim_row_t item_row(input logic [OP_W-1:0] op, input cell_t c,
                                           input logic [COLOR_W-1:0] color);
        stim_row_t r;
        r       = typed_row(op, c, color, 1'b0, BLANK);
        r.typed = 1'b0;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_W-1:0] val);
        stim_row_t r;
        r         = '0;
        r.kind    = ROW_CFG;
        r.cfg_idx = idx;
        r.cfg_val = val;
        return r;
    endfunction

    function automatic int unsigned clamp_extent(input int unsigned v, input int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void apply_size_write(input logic [CFG_INDEX_W-1:0] idx,
                                             input logic [CFG_W-1:0] data);
        case (idx)
            CFG_COLUMNS: grid_cols = clamp_extent(int'(data[COLS_W-1:0]), MAX_COLUMNS);
            CFG_ROWS:    grid_rows = clamp_extent(int'(data[ROWS_W-1:0]), MAX_ROWS);
            default:     return;
        endcase
        // a valid size write homes the position
        pos_col = 0;
        pos_row = 0;
    endfunction

    // visit the cell at the current position, update the shadow store, step on
    function automatic beat_t visit_cell(input logic [OP_W-1:0] op, input cell_t incoming,
                                         input logic [COLOR_W-1:0] color);
        beat_t       b;
        int unsigned addr;
        cell_t       held;
        addr     = pos_row * MAX_COLUMNS + pos_col;
        held     = frame_mem[addr];
        b.report = 1'b0;
        case (op)
            OP_MERGE:
                if (incoming.symbol != '0 && incoming != held)
                begin
                    held = incoming;
                    frame_mem[addr] = held;
                    b.report = 1'b1;
                end
            OP_COLOR: b.report = (held.foreground == color) || (held.background == color);
            OP_FULL:  b.report = 1'b1;
            default:  b.report = 1'b0;
        endcase
        b.col     = COL_W'(pos_col);
        b.row     = ROW_W'(pos_row);
        b.content = held;
        b.last    = (pos_col + 1 >= grid_cols) && (pos_row + 1 >= grid_rows);
        if (pos_col + 1 < grid_cols)
            pos_col = pos_col + 1;
        else
        begin
            pos_col = 0;
            pos_row = (pos_row + 1 < grid_rows) ? pos_row + 1 : 0;
        end
        return b;
    endfunction

    task automatic send_cell_op(input logic [OP_W-1:0] op, input cell_t c,
                                input logic [COLOR_W-1:0] color, input logic typed,
                                input logic t_report, input cell_t t_cell);
        beat_t want;
        operation     <= op;
        in_symbol     <= c.symbol;
        in_foreground <= c.foreground;
        in_background <= c.background;
        in_traits     <= c.traits;
        match_color   <= color;
        start         <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        want = visit_cell(op, c, color);
        if (typed)
        begin
            want.report  = t_report;
            want.content = t_cell;
        end
        pending_beats.insert(pending_beats.size(), want);
    endtask

    task automatic idle_sender(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    task automatic write_size_reg(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_size_write(idx, data);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // random content, biased toward the stored cell so equal merges and color hits occur
    task automatic send_random_cell();
        cell_t              held;
        cell_t              c;
        logic [OP_W-1:0]    op;
        logic [COLOR_W-1:0] color;
        int unsigned        pick;
        held         = frame_mem[pos_row * MAX_COLUMNS + pos_col];
        c.symbol     = SYM_W'($urandom_range(1, SYM_MAX));
        c.foreground = COLOR_W'($urandom);
        c.background = COLOR_W'($urandom);
        c.traits     = TRAIT_W'($urandom);
        color        = COLOR_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 45)
            op = OP_MERGE;
        else if (pick < 70)
            op = OP_COLOR;
        else if (pick < 92)
            op = OP_FULL;
        else
            op = OP_UNUSED;
        pick = $urandom_range(0, 7);
        if (op == OP_MERGE)
        begin
            if (pick == 0)
                c.symbol = '0;
            else if (pick <= 2 && held.symbol != '0)
                c = held;
            else if (pick == 3 && held.symbol != '0)
            begin
                c = held;
                case ($urandom_range(0, 3))
                    0: c.symbol     = SYM_W'($urandom_range(1, SYM_MAX));
                    1: c.foreground = ~held.foreground;
                    2: c.background = held.background ^ (8'd1 << $urandom_range(0, 7));
                    default: c.traits = TRAIT_W'($urandom);
                endcase
            end
        end
        else if (pick < 3)
            color = held.foreground;
        else if (pick < 6)
            color = held.background;
        send_cell_op(op, c, color, 1'b0, 1'b0, BLANK);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        beat_t want;
        if (rst_n && result_strobe)
        begin
            if (pending_beats.size() == 0)
            begin
                fail_count++;
                $display("%0t: result beat with nothing expected, expected none actual col %0h row %0h",
                         $time, cell_column, cell_row);
            end
            else
            begin
                want = pending_beats.pop_front();
                check_field("report", want.report, report);
                check_field("cell_column", want.col, cell_column);
                check_field("cell_row", want.row, cell_row);
                check_field("out_symbol", want.content.symbol, out_symbol);
                check_field("out_foreground", want.content.foreground, out_foreground);
                check_field("out_background", want.content.background, out_background);
                check_field("out_traits", want.content.traits, out_traits);
                check_field("last_cell", want.last, last_cell);
            end
        end
    end

    // run limit, covers the clear pass after reset
    initial
    begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int unsigned      random_items;
        int unsigned      phase;
        int unsigned      burst_left;
        int unsigned      phase_len;
        logic [CFG_W-1:0] col_data;
        logic [CFG_W-1:0] row_data;

        foreach (frame_mem[n])
            frame_mem[n] = '0;

        plan = '{
            // reset grid 80 x 24, store blank
            typed_row(OP_FULL, mk_cell('h10FFFF, 'hFF, 'hFF, 'hFF), 'hFF, 1, BLANK),
            typed_row(OP_COLOR, BLANK, 'h00, 1, BLANK),
            typed_row(OP_COLOR, BLANK, 'hFF, 0, BLANK),
            typed_row(OP_MERGE, mk_cell('h0, 'hFF, 'hFF, 'hFF), 'h00, 0, BLANK),
            typed_row(OP_MERGE, mk_cell('h10FFFF, 'hFF, 'hFF, 'hFF), 'h00, 1,
                      mk_cell('h10FFFF, 'hFF, 'hFF, 'hFF)),
            typed_row(OP_UNUSED, mk_cell('h10FFFF, 'hFF, 'hFF, 'hFF), 'hFF, 0, BLANK),
            typed_row(OP_MERGE, mk_cell('h1, 'h00, 'h00, 'h00), 'h00, 1,
                      mk_cell('h1, 'h00, 'h00, 'h00)),
            typed_row(OP_MERGE, BLANK, 'h00, 0, BLANK),
            // one-cell grid: repeated visits of the same cell
            cfg_row(CFG_COLUMNS, 'd1),
            cfg_row(CFG_ROWS, 'd1),
            typed_row(OP_MERGE, mk_cell('h41, 'h07, 'h00, 'h01), 'h00, 1,
                      mk_cell('h41, 'h07, 'h00, 'h01)),
            typed_row(OP_MERGE, mk_cell('h41, 'h07, 'h00, 'h01), 'h00, 0,
                      mk_cell('h41, 'h07, 'h00, 'h01)),
            typed_row(OP_MERGE, mk_cell('h41, 'h07, 'h00, 'h81), 'h00, 1,
                      mk_cell('h41, 'h07, 'h00, 'h81)),
            typed_row(OP_COLOR, BLANK, 'h00, 1, mk_cell('h41, 'h07, 'h00, 'h81)),
            typed_row(OP_COLOR, BLANK, 'h07, 1, mk_cell('h41, 'h07, 'h00, 'h81)),
            typed_row(OP_COLOR, BLANK, 'h55, 0, mk_cell('h41, 'h07, 'h00, 'h81)),
            typed_row(OP_MERGE, mk_cell('h0, 'h55, 'hAA, 'h7E), 'h00, 0,
                      mk_cell('h41, 'h07, 'h00, 'h81)),
            // zero sizes count as one
            cfg_row(CFG_COLUMNS, 'd0),
            cfg_row(CFG_ROWS, 'd0),
            typed_row(OP_FULL, BLANK, 'h00, 1, mk_cell('h41, 'h07, 'h00, 'h81)),
            // oversize values clamp to the full grid
            cfg_row(CFG_COLUMNS, 'h1FF),
            cfg_row(CFG_ROWS, 'h1FF),
            typed_row(OP_FULL, BLANK, 'h00, 1, mk_cell('h41, 'h07, 'h00, 'h81)),
            // unknown indexes change nothing, position kept
            cfg_row(CFG_SPARE_A, 'h1FF),
            cfg_row(CFG_SPARE_B, 'h155),
            item_row(OP_MERGE, mk_cell('h0AAAAA, 'h55, 'hAA, 'h55), 'h00),
            cfg_row(CFG_COLUMNS, 'd2),
            cfg_row(CFG_ROWS, 'd3),
            item_row(OP_MERGE, mk_cell('h0F0F0F, 'h0F, 'hF0, 'h3C), 'h00),
            item_row(OP_COLOR, BLANK, 'h0F),
            item_row(OP_FULL, BLANK, 'h00),
            item_row(OP_UNUSED, BLANK, 'h00),
            item_row(OP_MERGE, BLANK, 'h00)
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                drain_results();
                write_size_reg(plan[i].cfg_idx, plan[i].cfg_val);
            end
            else
                send_cell_op(plan[i].op, plan[i].in_cell, plan[i].color, plan[i].typed,
                             plan[i].t_report, plan[i].t_cell);
        end

        random_items = 0;
        phase        = 0;
        burst_left   = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            drain_results();
            // first two phases walk the widest row and the tallest column
            case (phase)
                0:
                begin
                    col_data  = 9'd256;
                    row_data  = 9'd1;
                    phase_len = 258;
                end
                1:
                begin
                    col_data  = 9'd1;
                    row_data  = 9'h180;
                    phase_len = 130;
                end
                default:
                begin
                    case ($urandom_range(0, 9))
                        0:       col_data = '0;
                        1:       col_data = CFG_W'($urandom_range(257, 511));
                        2:       col_data = 9'd256;
                        default: col_data = CFG_W'($urandom_range(1, 10));
                    endcase
                    case ($urandom_range(0, 9))
                        0:       row_data = '0;
                        1:       row_data = CFG_W'($urandom_range(129, 255));
                        2:       row_data = 9'd128;
                        default: row_data = CFG_W'($urandom_range(1, 8));
                    endcase
                    row_data[CFG_W-1] = 1'($urandom);
                    phase_len = $urandom_range(12, 60);
                end
            endcase
            if ($urandom_range(0, 1))
            begin
                write_size_reg(CFG_COLUMNS, col_data);
                write_size_reg(CFG_ROWS, row_data);
            end
            else
            begin
                write_size_reg(CFG_ROWS, row_data);
                write_size_reg(CFG_COLUMNS, col_data);
            end
            if ($urandom_range(0, 3) == 0)
                write_size_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                               CFG_W'($urandom));
            phase++;

            repeat (phase_len)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    if ($urandom_range(0, 3) != 0)
                        idle_sender($urandom_range(1, 6));
                end
                burst_left--;
                send_random_cell();
                random_items++;
                // one mid-phase pause until the pipe is empty
                if (random_items == RANDOM_ITEMS / 2)
                    drain_results();
            end
        end

        drain_results();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
